// File: hw/rtl/tcsg_pkg.sv
// shared types and constants of the texture column span generator
`default_nettype none

package tcsg_pkg;

  // fractional bits of the texture step and accumulator
  localparam int unsigned FRAC_BITS = 16;

  // payload widths
  localparam int unsigned ROW_IN_W   = 10;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned TCOL_W     = 6;
  localparam int unsigned SCOL_W     = 9;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned SOFF_W     = 15;
  localparam int unsigned TOFF_W     = 12;
  localparam int unsigned TEXNUM_W   = 3;
  localparam int unsigned MASK_W     = 8;

  // configuration port
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_TEXTURE_PRESENT_MASK = 2'd0;

  typedef enum logic [1:0] {
    STATUS_DRAWN       = 2'd0,
    STATUS_SKIPPED     = 2'd1,
    STATUS_BAD_TEXTURE = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcsg_cmd_if.sv
// column command channel
`default_nettype none

interface tcsg_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tcsg_pkg::ROW_IN_W-1:0] top_row;
  logic signed [tcsg_pkg::ROW_IN_W-1:0] bottom_row;
  logic        [tcsg_pkg::SEL_W-1:0]    texture_select;
  logic        [tcsg_pkg::TCOL_W-1:0]   texel_column;
  logic        [tcsg_pkg::SCOL_W-1:0]   screen_column;

  modport source (
    output valid, top_row, bottom_row, texture_select, texel_column, screen_column,
    input  ready
  );
  modport sink (
    input  valid, top_row, bottom_row, texture_select, texel_column, screen_column,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/tcsg_pix_if.sv
// pixel result channel
`default_nettype none

interface tcsg_pix_if;
  logic                            valid;
  logic                            ready;
  logic                            pixel_valid;
  logic [1:0]                      status;
  logic [tcsg_pkg::ROW_W-1:0]      screen_row;
  logic [tcsg_pkg::SOFF_W-1:0]     screen_offset;
  logic [tcsg_pkg::ROW_W-1:0]      texel_row;
  logic [tcsg_pkg::TOFF_W-1:0]     texel_offset;
  logic [tcsg_pkg::TEXNUM_W-1:0]   texture_number;
  logic                            last;

  modport source (
    output valid, pixel_valid, status, screen_row, screen_offset, texel_row,
           texel_offset, texture_number, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, status, screen_row, screen_offset, texel_row,
           texel_offset, texture_number, last,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/texture_column_span_generator_unit.sv
// top level: wall column span generator with a single restoring divider
// a culled, partly visible, empty or bad-texture command gives its single word
//   in the cycle after acceptance
// a drawn command runs through the restoring divider, one quotient bit per cycle,
//   then emits one word per cycle while the output is taken
// cmd.ready is high only while idle with the output register free or draining
// synchronous active high reset: idle, output empty, texture mask cleared
`default_nettype none

module texture_column_span_generator_unit #(
  parameter int unsigned TEX_SIDE      = 64,
  parameter int unsigned TEX_SIDE_LOG2 = 6,
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned TEXTURE_COUNT = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  tcsg_cmd_if.sink                                  cmd,
  tcsg_pix_if.source                                pix,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tcsg_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [tcsg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [tcsg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready
);

  // texel row bits, dividend width, divisor width, bit counter width, texel word width
  localparam int unsigned TROW_W = $clog2(TEX_SIDE);
  localparam int unsigned NUM_W  = TROW_W + tcsg_pkg::FRAC_BITS;
  localparam int unsigned HGT_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam int unsigned TWORD_W = TROW_W + TEX_SIDE_LOG2;

  localparam logic [NUM_W-1:0] NUMERATOR =
    NUM_W'((TEX_SIDE - 1) << tcsg_pkg::FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);
  localparam logic signed [tcsg_pkg::ROW_IN_W-1:0] HEIGHT_S =
    tcsg_pkg::ROW_IN_W'(SCREEN_HEIGHT);
  localparam logic [tcsg_pkg::SOFF_W-1:0] WIDTH_W = tcsg_pkg::SOFF_W'(SCREEN_WIDTH);
  localparam logic [tcsg_pkg::TCOL_W-1:0] TCOL_MASK =
    tcsg_pkg::TCOL_W'((1 << TEX_SIDE_LOG2) - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [tcsg_pkg::MASK_W-1:0] texture_present_mask;
  logic                        cfg_write;

  // held command
  logic [tcsg_pkg::TEXNUM_W-1:0] sel;
  logic [tcsg_pkg::TCOL_W-1:0]   tcol;
  logic [tcsg_pkg::ROW_W-1:0]    cur_row;
  logic [tcsg_pkg::ROW_W-1:0]    end_row;
  logic [tcsg_pkg::SOFF_W-1:0]   soff;

  // divider: quo holds the dividend, then the quotient (the step, 6.16 with a 64 texel side)
  logic [HGT_W-1:0] height;
  logic [HGT_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [HGT_W:0]   shifted;
  logic [HGT_W:0]   diff;
  logic             ge;

  // texture accumulator
  logic [NUM_W-1:0]   acc;
  logic [TROW_W-1:0]  trow;
  logic [TWORD_W-1:0] tex_word;

  // output register
  logic                          out_valid;
  logic                          out_load;
  logic                          out_pixel_valid;
  tcsg_pkg::status_t             out_status;
  logic [tcsg_pkg::ROW_W-1:0]    out_screen_row;
  logic [tcsg_pkg::SOFF_W-1:0]   out_screen_offset;
  logic [tcsg_pkg::ROW_W-1:0]    out_texel_row;
  logic [tcsg_pkg::TOFF_W-1:0]   out_texel_offset;
  logic [tcsg_pkg::TEXNUM_W-1:0] out_texture_number;
  logic                          out_last;

  // command decode
  logic                                 out_free;
  logic                                 cmd_take;
  logic                                 culled;
  logic                                 bad_tex;
  logic                                 empty_span;
  logic signed [tcsg_pkg::ROW_IN_W-1:0] span;
  logic [tcsg_pkg::SOFF_W-1:0]          soff_init;
  logic                                 row_last;

  // apb: always ready, single register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == tcsg_pkg::ADDR_TEXTURE_PRESENT_MASK);

  always_comb begin
    if (paddr == tcsg_pkg::ADDR_TEXTURE_PRESENT_MASK) begin
      prdata = tcsg_pkg::APB_DATA_W'(texture_present_mask);
    end else begin
      prdata = '0;
    end
  end

  // output register may be reloaded when empty or being taken this cycle
  assign out_free  = !out_valid || pix.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign cmd_take  = cmd.valid && cmd.ready;

  // partly visible columns are not clipped, they skip like culled ones
  assign culled = (cmd.top_row >= HEIGHT_S) || (cmd.bottom_row <= 0) ||
                  (cmd.top_row < 0) || (cmd.bottom_row >= HEIGHT_S);
  assign bad_tex = (32'(cmd.texture_select) >= TEXTURE_COUNT) ||
                   !texture_present_mask[cmd.texture_select[tcsg_pkg::TEXNUM_W-1:0]];
  assign empty_span = cmd.bottom_row < cmd.top_row;
  assign span       = cmd.bottom_row - cmd.top_row + 10'sd1;

  // a word enters the output register: a single status word or a pixel word
  assign out_load = (cmd_take && (culled || bad_tex || empty_span)) ||
                    ((state == S_EMIT) && out_free);

  // screen word of the top row, wrapping at 15 bits
  assign soff_init = tcsg_pkg::SOFF_W'(cmd.screen_column) +
                     tcsg_pkg::SOFF_W'(cmd.top_row[tcsg_pkg::ROW_W-1:0]) * WIDTH_W;

  // one restoring step: shift in the next dividend bit, trial subtract
  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = shifted - {1'b0, height};
  assign ge      = shifted >= {1'b0, height};

  // texel row is the integer part of the accumulator
  assign trow     = acc[NUM_W-1:tcsg_pkg::FRAC_BITS];
  assign tex_word = (TWORD_W'(trow) << TEX_SIDE_LOG2) + TWORD_W'(tcol);
  assign row_last = cur_row == end_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      out_valid            <= 1'b0;
      texture_present_mask <= '0;
      cnt                  <= '0;
    end else begin
      if (cfg_write) begin
        texture_present_mask <= pwdata[tcsg_pkg::MASK_W-1:0];
      end
      // held until taken, refilled on a new word
      out_valid <= out_load || (out_valid && !pix.ready);

      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            if (culled || bad_tex || empty_span) begin
              // single status word, checks in priority order
              out_pixel_valid    <= 1'b0;
              out_status         <= (!culled && bad_tex) ? tcsg_pkg::STATUS_BAD_TEXTURE
                                                         : tcsg_pkg::STATUS_SKIPPED;
              out_screen_row     <= '0;
              out_screen_offset  <= '0;
              out_texel_row      <= '0;
              out_texel_offset   <= '0;
              out_texture_number <= '0;
              out_last           <= 1'b1;
            end else begin
              sel     <= cmd.texture_select[tcsg_pkg::TEXNUM_W-1:0];
              tcol    <= cmd.texel_column & TCOL_MASK;
              cur_row <= cmd.top_row[tcsg_pkg::ROW_W-1:0];
              end_row <= cmd.bottom_row[tcsg_pkg::ROW_W-1:0];
              soff    <= soff_init;
              height  <= HGT_W'(span);
              rem     <= '0;
              quo     <= NUMERATOR;
              cnt     <= '0;
              state   <= S_DIV;
            end
          end
        end

        S_DIV: begin
          quo <= {quo[NUM_W-2:0], ge};
          rem <= ge ? HGT_W'(diff) : HGT_W'(shifted);
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            acc   <= '0;
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_pixel_valid    <= 1'b1;
            out_status         <= tcsg_pkg::STATUS_DRAWN;
            out_screen_row     <= cur_row;
            out_screen_offset  <= soff;
            out_texel_row      <= tcsg_pkg::ROW_W'(trow);
            out_texel_offset   <= tcsg_pkg::TOFF_W'(tex_word);
            out_texture_number <= sel;
            out_last           <= row_last;
            acc                <= acc + quo;
            cur_row            <= cur_row + 1'b1;
            soff               <= soff + WIDTH_W;
            if (row_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pix.valid          = out_valid;
  assign pix.pixel_valid    = out_pixel_valid;
  assign pix.status         = out_status;
  assign pix.screen_row     = out_screen_row;
  assign pix.screen_offset  = out_screen_offset;
  assign pix.texel_row      = out_texel_row;
  assign pix.texel_offset   = out_texel_offset;
  assign pix.texture_number = out_texture_number;
  assign pix.last           = out_last;

  // partial remainder stays below the divisor
  a_rem_below_height: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < height))
    else $error("divider remainder not below span height");

  // emission never runs past the bottom row
  a_row_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (cur_row <= end_row))
    else $error("row counter beyond bottom row");

  // texel row stays inside the texture while emitting
  a_trow_in_texture: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (32'(trow) < TEX_SIDE))
    else $error("texel row outside texture");

  // status words are single and final, pixel words are drawn
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.pixel_valid) |->
      (pix.last && (pix.status != tcsg_pkg::STATUS_DRAWN)))
    else $error("status word malformed");

  a_pixel_word: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.pixel_valid) |-> (pix.status == tcsg_pkg::STATUS_DRAWN))
    else $error("pixel word without drawn status");

endmodule

`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for the texture column span generator unit
`timescale 1ns / 1ps

module tb;

  // block configuration, kept equal to the defaults of the top level
  localparam int unsigned TEX_SIDE      = 64;
  localparam int unsigned TEX_SIDE_LOG2 = 6;
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned TEXTURE_COUNT = 8;

  // cycles with no word moving on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 5000;

  // one column command as it goes onto the command channel
  typedef struct packed {
    logic signed [tcsg_pkg::ROW_IN_W-1:0] top_row;
    logic signed [tcsg_pkg::ROW_IN_W-1:0] bottom_row;
    logic        [tcsg_pkg::SEL_W-1:0]    texture_select;
    logic        [tcsg_pkg::TCOL_W-1:0]   texel_column;
    logic        [tcsg_pkg::SCOL_W-1:0]   screen_column;
  } column_cmd_t;

  // one word on the pixel channel
  typedef struct packed {
    logic                          pixel_valid;
    tcsg_pkg::status_t             status;
    logic [tcsg_pkg::ROW_W-1:0]    screen_row;
    logic [tcsg_pkg::SOFF_W-1:0]   screen_offset;
    logic [tcsg_pkg::ROW_W-1:0]    texel_row;
    logic [tcsg_pkg::TOFF_W-1:0]   texel_offset;
    logic [tcsg_pkg::TEXNUM_W-1:0] texture_number;
    logic                          last;
  } pixel_word_t;

  logic clk;
  logic rst;

  tcsg_cmd_if cmd_ch ();
  tcsg_pix_if pix_ch ();

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [tcsg_pkg::APB_ADDR_W-1:0] paddr;
  logic [tcsg_pkg::APB_DATA_W-1:0] pwdata;
  wire  [tcsg_pkg::APB_DATA_W-1:0] prdata;
  wire                             pready;

  // our own copy of the texture mask, updated on each register write
  logic [tcsg_pkg::MASK_W-1:0] mask_model;

  // pixel words still owed by the block, oldest first
  pixel_word_t pending_pixels[$];

  // percentage of cycles in which each side holds back
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned fail_count;
  int unsigned stall_cycles;

  texture_column_span_generator_unit #(
    .TEX_SIDE      (TEX_SIDE),
    .TEX_SIDE_LOG2 (TEX_SIDE_LOG2),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEXTURE_COUNT (TEXTURE_COUNT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .pix     (pix_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // span predictor: works out every word a command should give
  // ---------------------------------------------------------------------
  function automatic void predict_column(input column_cmd_t c);
    int          top;
    int          bot;
    int unsigned step;
    int unsigned acc;
    int unsigned trow;
    pixel_word_t w;
    top = $signed(c.top_row);
    bot = $signed(c.bottom_row);
    w = '0;
    w.status = tcsg_pkg::STATUS_SKIPPED;
    w.last = 1'b1;
    // culled or only partly on screen: no clipping, just a skip word
    if (top >= int'(SCREEN_HEIGHT) || bot <= 0 || top < 0 || bot >= int'(SCREEN_HEIGHT)) begin
      pending_pixels.push_back(w);
      return;
    end
    // slot out of range or not loaded; checked ahead of the empty span
    if (c.texture_select >= TEXTURE_COUNT ||
        !mask_model[c.texture_select[tcsg_pkg::TEXNUM_W-1:0]]) begin
      w.status = tcsg_pkg::STATUS_BAD_TEXTURE;
      pending_pixels.push_back(w);
      return;
    end
    // bottom above top: nothing to divide by, skipped
    if (bot < top) begin
      pending_pixels.push_back(w);
      return;
    end
    // 16.16 step over the texture height, accumulator starts at zero
    step = ((TEX_SIDE - 1) << tcsg_pkg::FRAC_BITS) / (bot - top + 1);
    acc = 0;
    for (int r = top; r <= bot; r++) begin
      trow = acc >> tcsg_pkg::FRAC_BITS;
      w.pixel_valid    = 1'b1;
      w.status         = tcsg_pkg::STATUS_DRAWN;
      w.screen_row     = tcsg_pkg::ROW_W'(r);
      w.screen_offset  = tcsg_pkg::SOFF_W'(c.screen_column + r * SCREEN_WIDTH);
      w.texel_row      = tcsg_pkg::ROW_W'(trow);
      w.texel_offset   = tcsg_pkg::TOFF_W'((c.texel_column & ((1 << TEX_SIDE_LOG2) - 1))
                                           + (trow << TEX_SIDE_LOG2));
      w.texture_number = c.texture_select[tcsg_pkg::TEXNUM_W-1:0];
      w.last           = (r == bot);
      pending_pixels.push_back(w);
      acc += step;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // pixel channel: random back-pressure and the word checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // sampled mid-cycle, so the values are the ones the next rising edge takes
  always @(negedge clk) begin
    pixel_word_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel word with nothing expected: status %0d row %0d",
               pix_ch.status, pix_ch.screen_row);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_valid",    want.pixel_valid,    pix_ch.pixel_valid);
        check_field("status",         want.status,         pix_ch.status);
        check_field("screen_row",     want.screen_row,     pix_ch.screen_row);
        check_field("screen_offset",  want.screen_offset,  pix_ch.screen_offset);
        check_field("texel_row",      want.texel_row,      pix_ch.texel_row);
        check_field("texel_offset",   want.texel_offset,   pix_ch.texel_offset);
        check_field("texture_number", want.texture_number, pix_ch.texture_number);
        check_field("last",           want.last,           pix_ch.last);
      end
    end
  end

  // watchdog: any cycle where no word moves counts toward the limit
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // shared drivers; every task starts and ends in a rising-edge time step
  // ---------------------------------------------------------------------

  // present one command, wait for the handshake, then predict its words
  task automatic send_column(input column_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.top_row        <= c.top_row;
    cmd_ch.bottom_row     <= c.bottom_row;
    cmd_ch.texture_select <= c.texture_select;
    cmd_ch.texel_column   <= c.texel_column;
    cmd_ch.screen_column  <= c.screen_column;
    do @(negedge clk); while (!cmd_ch.ready);
    @(posedge clk);
    predict_column(c);
  endtask

  task automatic send_fields(input int top, input int bot, input int sel,
                             input int tcol, input int scol);
    column_cmd_t c;
    c.top_row        = tcsg_pkg::ROW_IN_W'(top);
    c.bottom_row     = tcsg_pkg::ROW_IN_W'(bot);
    c.texture_select = tcsg_pkg::SEL_W'(sel);
    c.texel_column   = tcsg_pkg::TCOL_W'(tcol);
    c.screen_column  = tcsg_pkg::SCOL_W'(scol);
    send_column(c);
  endtask

  // stop sending and wait until every owed word has arrived and the
  // single-word path has had time to settle
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // two-phase register write; upper data bits carry junk the block drops
  task automatic write_mask(input logic [tcsg_pkg::MASK_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tcsg_pkg::ADDR_TEXTURE_PRESENT_MASK;
    pwdata  <= {(tcsg_pkg::APB_DATA_W - tcsg_pkg::MASK_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mask_model = value;
    // read back the register through the same address
    @(negedge clk);
    check_field("prdata", tcsg_pkg::APB_DATA_W'(value), prdata);
    @(posedge clk);
  endtask

  // random command: mostly well-formed visible spans, some empty spans,
  // the rest raw noise over every bit
  function automatic column_cmd_t random_column();
    column_cmd_t c;
    int          top;
    int          bot;
    int          height;
    int unsigned pick;
    pick = $urandom_range(99);
    c.texel_column  = tcsg_pkg::TCOL_W'($urandom_range(63));
    c.screen_column = ($urandom_range(9) == 0) ? tcsg_pkg::SCOL_W'($urandom_range(320, 511))
                                               : tcsg_pkg::SCOL_W'($urandom_range(319));
    c.texture_select = ($urandom_range(9) == 0) ? tcsg_pkg::SEL_W'($urandom_range(8, 15))
                                                : tcsg_pkg::SEL_W'($urandom_range(7));
    if (pick < 75) begin
      // short spans keep the run quick; every fifth or so is tall
      top = $urandom_range(SCREEN_HEIGHT - 1);
      height = ($urandom_range(4) == 0) ? $urandom_range(1, SCREEN_HEIGHT)
                                        : $urandom_range(1, 8);
      bot = top + height - 1;
      if (bot > int'(SCREEN_HEIGHT) - 1) bot = SCREEN_HEIGHT - 1;
    end else if (pick < 88) begin
      top = $urandom_range(2, SCREEN_HEIGHT - 1);
      bot = $urandom_range(1, top - 1);
    end else begin
      top = $urandom;
      bot = $urandom;
      c.texture_select = tcsg_pkg::SEL_W'($urandom);
      c.texel_column   = tcsg_pkg::TCOL_W'($urandom);
      c.screen_column  = tcsg_pkg::SCOL_W'($urandom);
    end
    c.top_row    = tcsg_pkg::ROW_IN_W'(top);
    c.bottom_row = tcsg_pkg::ROW_IN_W'(bot);
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------

  // mask comes out of reset empty, so a good span must report a bad texture
  task automatic test_reset_mask();
    send_fields(10, 20, 0, 5, 100);
    wait_for_drain();
    write_mask(8'hFF);
  endtask

  // off-screen and partly visible strips each give one skip word
  task automatic test_culling();
    send_fields(64, 70, 1, 0, 0);
    send_fields(511, 511, 2, 63, 319);
    send_fields(0, 0, 3, 1, 1);
    send_fields(-512, -512, 4, 2, 2);
    send_fields(-1, 10, 5, 3, 3);
    send_fields(10, 64, 6, 4, 4);
    send_fields(-512, 511, 7, 63, 511);
  endtask

  // slot range, unloaded slot, and the order of the checks
  task automatic test_texture_faults();
    send_fields(5, 9, 8, 7, 7);
    send_fields(5, 9, 15, 7, 7);
    // culling wins over a bad slot
    send_fields(70, 80, 15, 0, 0);
    // bad slot wins over an empty span
    send_fields(40, 39, 12, 0, 0);
    wait_for_drain();
    write_mask(8'h7F);
    send_fields(3, 6, 7, 9, 50);
    send_fields(3, 6, 6, 9, 50);
    wait_for_drain();
    write_mask(8'hFF);
  endtask

  // span shapes and column extremes
  task automatic test_span_edges();
    send_fields(40, 39, 0, 0, 0);
    send_fields(63, 63, 1, 63, 511);
    send_fields(0, 63, 2, 0, 0);
    send_fields(1, 63, 3, 63, 319);
    send_fields(20, 27, 7, 32, 511);
  endtask

  task automatic test_random_columns(input int unsigned count, input bit pause_midway);
    for (int unsigned i = 0; i < count; i++) begin
      // sender holds off until everything owed has arrived
      if (pause_midway && i == count / 2) wait_for_drain();
      send_column(random_column());
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    fail_count    = 0;
    mask_model    = '0;
    send_idle_pct = 14;
    recv_idle_pct = 88;
    rst                   <= 1'b1;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.top_row        <= '0;
    cmd_ch.bottom_row     <= '0;
    cmd_ch.texture_select <= '0;
    cmd_ch.texel_column   <= '0;
    cmd_ch.screen_column  <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_mask();
    test_culling();
    test_texture_faults();
    test_span_edges();
    wait_for_drain();

    // slow receiver, all slots loaded
    test_random_columns(80, 1'b0);

    // slow sender, random slot set, with a full pause part way through
    send_idle_pct = 88;
    recv_idle_pct = 14;
    write_mask(tcsg_pkg::MASK_W'($urandom_range(255)));
    test_random_columns(80, 1'b1);

    // no idling: empty mask first, then another random set
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mask(8'h00);
    test_random_columns(10, 1'b0);
    write_mask(tcsg_pkg::MASK_W'($urandom_range(255)));
    test_random_columns(40, 1'b0);

    // let any stray word show itself
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (pending_pixels.size() != 0) $error("%0d pixel words never arrived",
                                             pending_pixels.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
